@@ src/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked on the next rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ src/cis_pkg.sv @@
// Shared types and constants of the item skipper.
package cis_pkg;
    localparam int MaxNestingDefault = 8;
    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_DONE  = 3'd1;
    localparam logic [2:0] ST_BAD   = 3'd2;
    localparam logic [2:0] ST_INDEF = 3'd3;
    localparam logic [2:0] ST_DEEP  = 3'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] bytes_after;
        logic        restart;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        head_valid;
        logic [2:0]  major_type;
        logic [63:0] argument;
        logic [3:0]  nesting_depth;
    } result_t;
endpackage

@@ src/cis_front.sv @@
// Two-entry input skid queue that accepts items and holds them for the back end.
module cis_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  cis_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_take,
    output cis_pkg::item_t q_item
);
    cis_pkg::item_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       do_push, do_pop;

    assign full    = cnt_reg[1];
    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = buf_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_reg] <= in_item;
        end
    end
endmodule

@@ src/cis_back.sv @@
// Back end that parses each byte, pops nesting levels and queues the results.
module cis_back
#(
    parameter int MAX_NESTING = cis_pkg::MaxNestingDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      buffer_size,
    input  logic             q_valid,
    output logic             q_take,
    input  cis_pkg::item_t   q_item,
    output logic             empty,
    input  logic             pop,
    output cis_pkg::result_t res
);
    localparam int LW = $clog2(MAX_NESTING + 1);
    localparam int SW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    typedef enum logic [1:0] {
        S_WORK = 2'b01,
        S_POP  = 2'b10
    } fsm_t;

    typedef enum logic [3:0] {
        PH_HEAD    = 4'b0001,
        PH_ARG     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    fsm_t        fsm_reg, fsm_next;
    phase_t      ph_reg, ph_next;
    logic [3:0]  abl_reg, abl_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  hmt_reg, hmt_next;
    logic [4:0]  hai_reg, hai_next;
    logic [31:0] pl_reg, pl_next;
    logic [32:0] owed_reg, owed_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [2:0]  held_reg, held_next;
    logic [32:0] stk_reg [MAX_NESTING];
    logic        stk_we;
    logic [32:0] stk_wd;

    cis_pkg::result_t pend_reg, pend_next;
    cis_pkg::result_t oq_reg [2];
    logic [1:0]  ocnt_reg;
    logic        ord_reg, owr_reg;
    logic        o_push, o_pop, ofree;

    logic [7:0]  b;
    logic [31:0] after;
    logic        rs;
    phase_t      ph_c;
    logic [32:0] owed_c;
    logic [LW-1:0] lv_c;
    logic [2:0]  st;
    logic        hv, fin, do_pop_lv;
    logic [63:0] v, argv;
    logic [2:0]  mt;
    logic [4:0]  ai;
    logic [3:0]  n;

    assign b     = q_item.data_byte;
    assign after = q_item.bytes_after;
    assign rs    = q_item.restart;
    assign ofree = ocnt_reg != 2'd2;
    assign q_take = (fsm_reg == S_WORK) && q_valid && ofree;
    assign empty = ocnt_reg == 2'd0;
    assign res   = oq_reg[ord_reg];
    assign o_pop = pop && !empty;

    always_comb
    begin
        ph_c   = rs ? PH_HEAD : ph_reg;
        owed_c = rs ? 33'd1 : owed_reg;
        lv_c   = rs ? '0 : lv_reg;
        fsm_next = fsm_reg;
        ph_next  = ph_reg;
        abl_next = abl_reg;
        acc_next = acc_reg;
        hmt_next = hmt_reg;
        hai_next = hai_reg;
        pl_next  = pl_reg;
        owed_next = owed_reg;
        lv_next  = lv_reg;
        held_next = held_reg;
        pend_next = pend_reg;
        stk_we = 1'b0;
        stk_wd = owed_reg;
        o_push = 1'b0;
        st = cis_pkg::ST_RUN;
        hv = 1'b0;
        fin = 1'b0;
        argv = '0;
        v = '0;
        mt = hmt_reg;
        ai = hai_reg;
        n = 4'd0;
        do_pop_lv = 1'b0;
        if (fsm_reg == S_POP)
        begin
            lv_next   = lv_reg - 1'b1;
            owed_next = stk_reg[SW'(lv_reg - 1'b1)];
            if (stk_reg[SW'(lv_reg - 1'b1)] == 33'd0 && lv_reg != LW'(1))
            begin
                fsm_next = S_POP;
            end
            else
            begin
                fsm_next = S_WORK;
                pend_next.nesting_depth = 4'(lv_reg - 1'b1);
                if (stk_reg[SW'(lv_reg - 1'b1)] == 33'd0 && ph_reg == PH_HEAD)
                begin
                    pend_next.status = cis_pkg::ST_DONE;
                end
                if (pend_next.status != cis_pkg::ST_RUN)
                begin
                    ph_next   = PH_DONE;
                    held_next = pend_next.status;
                end
                o_push = 1'b1;
            end
        end
        else if (q_take)
        begin
            ph_next   = ph_c;
            owed_next = owed_c;
            lv_next   = lv_c;
            if (rs)
            begin
                held_next = cis_pkg::ST_RUN;
                pl_next   = '0;
                abl_next  = '0;
            end
            if (ph_c == PH_DONE)
            begin
                st = held_reg;
            end
            else
            begin
                if (ph_c == PH_HEAD)
                begin
                    mt = b[7:5];
                    ai = b[4:0];
                    hmt_next = mt;
                    hai_next = ai;
                    if (ai <= 5'd23)
                    begin
                        fin = 1'b1;
                        v = {59'd0, ai};
                    end
                    else if (ai <= 5'd27)
                    begin
                        n = 4'd1 << ai[1:0];
                        if ({28'd0, n} > after)
                        begin
                            st = cis_pkg::ST_BAD;
                        end
                        else
                        begin
                            acc_next = '0;
                            abl_next = n;
                            ph_next  = PH_ARG;
                        end
                    end
                    else if (ai == 5'd31)
                    begin
                        st = cis_pkg::ST_INDEF;
                    end
                    else
                    begin
                        st = cis_pkg::ST_BAD;
                    end
                end
                else if (ph_c == PH_ARG)
                begin
                    acc_next = {acc_reg[55:0], b};
                    abl_next = abl_reg - 4'd1;
                    if (abl_reg <= 4'd1)
                    begin
                        fin = 1'b1;
                        v = acc_next;
                    end
                end
                else
                begin
                    if (pl_reg > 32'd1)
                    begin
                        pl_next = pl_reg - 32'd1;
                    end
                    else
                    begin
                        pl_next = '0;
                        ph_next = PH_HEAD;
                        if (owed_c == 33'd0)
                        begin
                            st = cis_pkg::ST_DONE;
                        end
                    end
                end
                if (fin)
                begin
                    hv = 1'b1;
                    argv = v;
                    ph_next = PH_HEAD;
                    if (mt == 3'd7 && ai == 5'd24 && v < 64'd32)
                    begin
                        st = cis_pkg::ST_BAD;
                    end
                    else if (mt != 3'd7 && ((ai == 5'd24 && v < 64'd24)
                        || (ai == 5'd25 && v < 64'd256)
                        || (ai == 5'd26 && v < 64'h10000)
                        || (ai == 5'd27 && v < 64'h100000000)))
                    begin
                        st = cis_pkg::ST_BAD;
                    end
                    else if ((mt == 3'd2 || mt == 3'd3) && v > {32'd0, after})
                    begin
                        st = cis_pkg::ST_BAD;
                    end
                    else
                    begin
                        if (mt == 3'd2 || mt == 3'd3)
                        begin
                            pl_next = v[31:0];
                            if (v != 64'd0)
                            begin
                                ph_next = PH_PAYLOAD;
                            end
                        end
                        owed_next = owed_c - 33'd1;
                        if ((mt == 3'd4 || mt == 3'd5) && v != 64'd0)
                        begin
                            if (lv_c >= LW'(MAX_NESTING))
                            begin
                                st = cis_pkg::ST_DEEP;
                            end
                            else if (v > {32'd0, buffer_size})
                            begin
                                st = cis_pkg::ST_BAD;
                            end
                            else
                            begin
                                stk_we = 1'b1;
                                stk_wd = owed_next;
                                lv_next = lv_c + 1'b1;
                                owed_next = (mt == 3'd5) ? {v[31:0], 1'b0} : v[32:0];
                            end
                        end
                        else if (mt == 3'd6)
                        begin
                            owed_next = owed_c;
                        end
                        if (st == cis_pkg::ST_RUN)
                        begin
                            if (owed_next == 33'd0 && lv_next != '0)
                            begin
                                do_pop_lv = 1'b1;
                            end
                            else if (owed_next == 33'd0 && ph_next == PH_HEAD)
                            begin
                                st = cis_pkg::ST_DONE;
                            end
                        end
                    end
                end
                if (do_pop_lv)
                begin
                    // Final status waits until the pops have finished.
                    fsm_next = S_POP;
                end
                else
                begin
                    if (st == cis_pkg::ST_RUN && after == 32'd0)
                    begin
                        st = cis_pkg::ST_BAD;
                    end
                    if (st != cis_pkg::ST_RUN)
                    begin
                        ph_next   = PH_DONE;
                        held_next = st;
                    end
                end
            end
            pend_next.status     = st;
            pend_next.head_valid = hv;
            pend_next.major_type = hv ? mt : 3'd0;
            pend_next.argument   = argv;
            pend_next.nesting_depth = 4'(lv_next);
            if (do_pop_lv)
            begin
                pend_next.status = (after == 32'd0) ? cis_pkg::ST_BAD : cis_pkg::ST_RUN;
            end
            else
            begin
                o_push = 1'b1;
            end
        end
    end

    // After the pops the truncation check overrides only a running status.
    cis_pkg::result_t pend_fix;
    logic after0_reg;
    always_comb
    begin
        pend_fix = pend_next;
        if (fsm_reg == S_POP)
        begin
            pend_fix.status = pend_next.status;
            if (pend_next.status == cis_pkg::ST_BAD && !after0_reg)
            begin
                pend_fix.status = cis_pkg::ST_RUN;
            end
            if (pend_next.status == cis_pkg::ST_DONE)
            begin
                pend_fix.status = cis_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg  <= S_WORK;
            ph_reg   <= PH_HEAD;
            abl_reg  <= '0;
            hmt_reg  <= '0;
            hai_reg  <= '0;
            pl_reg   <= '0;
            owed_reg <= 33'd1;
            lv_reg   <= '0;
            held_reg <= cis_pkg::ST_RUN;
            ocnt_reg <= 2'd0;
            ord_reg  <= 1'b0;
            owr_reg  <= 1'b0;
            after0_reg <= 1'b0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            abl_reg  <= abl_next;
            hmt_reg  <= hmt_next;
            hai_reg  <= hai_next;
            pl_reg   <= pl_next;
            owed_reg <= owed_next;
            lv_reg   <= lv_next;
            if (fsm_reg == S_POP && fsm_next == S_WORK)
            begin
                if (pend_fix.status != cis_pkg::ST_RUN)
                begin
                    ph_reg   <= PH_DONE;
                    held_reg <= pend_fix.status;
                end
                else
                begin
                    ph_reg   <= ph_reg;
                    held_reg <= held_reg;
                end
            end
            else
            begin
                ph_reg   <= ph_next;
                held_reg <= held_next;
            end
            if (q_take)
            begin
                after0_reg <= (after == 32'd0);
            end
            if (o_push)
            begin
                owr_reg <= !owr_reg;
            end
            if (o_pop)
            begin
                ord_reg <= !ord_reg;
            end
            ocnt_reg <= ocnt_reg + {1'b0, o_push} - {1'b0, o_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        pend_reg <= pend_fix;
        if (stk_we)
        begin
            stk_reg[SW'(lv_c)] <= stk_wd;
        end
        if (o_push)
        begin
            oq_reg[owr_reg] <= pend_fix;
        end
    end
endmodule

@@ src/cbor_item_skipper.sv @@
// Top level of the streaming CBOR item skipper.
// Each accepted byte is parsed as it is taken; a byte that closes nesting levels
// then holds off the input while the owed-item stack pops one level per cycle.
// Up to two items wait on the input side and two results on the output side.
// buffer_size bounds array and map counts; write it only while idle.
module cbor_item_skipper
#(
    parameter int MAX_NESTING = cis_pkg::MaxNestingDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic [31:0] bytes_after,
    input  logic        restart,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic        head_valid,
    output logic [2:0]  major_type,
    output logic [63:0] argument,
    output logic [3:0]  nesting_depth
);
    logic [31:0]      buffer_size_reg;
    cis_pkg::item_t   in_item, q_item;
    cis_pkg::result_t res;
    logic             q_valid, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            buffer_size_reg <= cfg_wdata;
        end
    end

    assign in_item = '{data_byte: data_byte, bytes_after: bytes_after, restart: restart};

    cis_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    cis_back #(.MAX_NESTING(MAX_NESTING)) u_back
    (
        .clk(clk), .rst_n(rst_n), .buffer_size(buffer_size_reg),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
        .empty(empty), .pop(pop), .res(res)
    );

    assign status        = res.status;
    assign head_valid    = res.head_valid;
    assign major_type    = res.major_type;
    assign argument      = res.argument;
    assign nesting_depth = res.nesting_depth;
endmodule

@@ src/cis_checker.sv @@
// Port-level checker for the item skipper, bound to the top level.
`include "assert_macros.svh"
module cis_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic        head_valid,
    input logic [2:0]  major_type,
    input logic [63:0] argument,
    input logic [3:0]  nesting_depth
);
    `ASSERT_IMPLIES(a_status_range, clk, rst_n, !empty, status <= 3'd4)
    `ASSERT_IMPLIES(a_no_head_zero, clk, rst_n, !empty && !head_valid,
        major_type == 3'd0 && argument == 64'd0)
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(argument))
    `ASSERT_IMPLIES(a_done_depth, clk, rst_n, !empty && status == 3'd1 && head_valid,
        nesting_depth == 4'd0)
endmodule

bind cbor_item_skipper cis_checker u_cis_checker
(
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .status(status), .head_valid(head_valid), .major_type(major_type),
    .argument(argument), .nesting_depth(nesting_depth)
);

@@ bench/tb_cbor_item_skipper.sv @@
// Self-checking testbench for the CBOR item skipper with a built-in parser predictor.
module tb_cbor_item_skipper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEST = 8;
    localparam logic [2:0] MT_UINT = 3'd0;
    localparam logic [2:0] MT_NINT = 3'd1;
    localparam logic [2:0] MT_BSTR = 3'd2;
    localparam logic [2:0] MT_TSTR = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP = 3'd5;
    localparam logic [2:0] MT_TAG = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;
    localparam logic [4:0] AI_DIRECT_MAX = 5'd23;
    localparam logic [4:0] AI_ARG1 = 5'd24;
    localparam logic [4:0] AI_ARG2 = 5'd25;
    localparam logic [4:0] AI_ARG4 = 5'd26;
    localparam logic [4:0] AI_ARG8 = 5'd27;
    localparam logic [4:0] AI_INDEF = 5'd31;

    typedef enum logic [1:0] {P_HEAD, P_ARG, P_PAYLOAD, P_FINISHED} parse_phase_t;
    typedef logic [7:0] byte_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic [31:0] bytes_after = '0;
    logic        restart = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  status;
    logic        head_valid;
    logic [2:0]  major_type;
    logic [63:0] argument;
    logic [3:0]  nesting_depth;

    cbor_item_skipper u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .push(push), .full(full), .data_byte(data_byte), .bytes_after(bytes_after),
        .restart(restart), .empty(empty), .pop(pop), .status(status),
        .head_valid(head_valid), .major_type(major_type), .argument(argument),
        .nesting_depth(nesting_depth)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state.
    logic [31:0]  msg_size;
    parse_phase_t pphase;
    logic [3:0]   arg_left;
    logic [63:0]  arg_acc;
    logic [2:0]   cur_major;
    logic [4:0]   cur_info;
    logic [31:0]  skip_left;
    logic [32:0]  owed;
    logic [3:0]   levels;
    logic [32:0]  owed_save [NEST];
    logic [2:0]   held;

    cis_pkg::item_t   pending_bytes[$];
    cis_pkg::result_t expected_heads[$];
    cis_pkg::item_t   cur_item;
    int      errors = 0;
    int      cycle_count = 0;
    logic    calm;
    byte_q_t gen_bytes;

    function automatic void clear_parser();
        pphase = P_HEAD;
        arg_left = '0;
        arg_acc = '0;
        cur_major = '0;
        cur_info = '0;
        skip_left = '0;
        owed = 33'd1;
        levels = '0;
        for (int i = 0; i < NEST; i++)
            owed_save[i] = '0;
        held = cis_pkg::ST_RUN;
    endfunction

    function automatic logic [2:0] close_head(logic [63:0] v, logic [31:0] after);
        pphase = P_HEAD;
        if (cur_major == MT_SIMPLE && cur_info == AI_ARG1 && v < 64'd32)
            return cis_pkg::ST_BAD;
        if (cur_major != MT_SIMPLE &&
            ((cur_info == AI_ARG1 && v < 64'd24) || (cur_info == AI_ARG2 && v < 64'd256) ||
             (cur_info == AI_ARG4 && v < 64'h10000) ||
             (cur_info == AI_ARG8 && v < 64'h1_0000_0000)))
            return cis_pkg::ST_BAD;
        if (cur_major == MT_BSTR || cur_major == MT_TSTR)
        begin
            if (v > {32'd0, after})
                return cis_pkg::ST_BAD;
            skip_left = v[31:0];
            if (v != 0)
                pphase = P_PAYLOAD;
        end
        owed = owed - 33'd1;
        if ((cur_major == MT_ARRAY || cur_major == MT_MAP) && v != 0)
        begin
            if (levels >= NEST)
                return cis_pkg::ST_DEEP;
            if (v > {32'd0, msg_size})
                return cis_pkg::ST_BAD;
            owed_save[levels[2:0]] = owed;
            levels = levels + 4'd1;
            owed = (cur_major == MT_MAP) ? {v[31:0], 1'b0} : v[32:0];
        end
        else if (cur_major == MT_TAG)
            owed = owed + 33'd1;
        while (owed == 0 && levels > 0)
        begin
            levels = levels - 4'd1;
            owed = owed_save[levels[2:0]];
        end
        if (owed == 0 && pphase == P_HEAD)
            return cis_pkg::ST_DONE;
        return cis_pkg::ST_RUN;
    endfunction

    function automatic cis_pkg::result_t parse_byte(cis_pkg::item_t it);
        cis_pkg::result_t r;
        logic [3:0] n;
        r = '0;
        r.status = cis_pkg::ST_RUN;
        if (it.restart)
            clear_parser();
        if (pphase == P_FINISHED)
            r.status = held;
        else
        begin
            if (pphase == P_HEAD)
            begin
                cur_major = it.data_byte[7:5];
                cur_info = it.data_byte[4:0];
                if (cur_info <= AI_DIRECT_MAX)
                begin
                    r.head_valid = 1'b1;
                    r.argument = {59'd0, cur_info};
                    r.major_type = cur_major;
                    r.status = close_head(r.argument, it.bytes_after);
                end
                else if (cur_info <= AI_ARG8)
                begin
                    n = 4'd1 << (cur_info - AI_ARG1);
                    if ({28'd0, n} > it.bytes_after)
                        r.status = cis_pkg::ST_BAD;
                    else
                    begin
                        arg_acc = '0;
                        arg_left = n;
                        pphase = P_ARG;
                    end
                end
                else if (cur_info == AI_INDEF)
                    r.status = cis_pkg::ST_INDEF;
                else
                    r.status = cis_pkg::ST_BAD;
            end
            else if (pphase == P_ARG)
            begin
                arg_acc = {arg_acc[55:0], it.data_byte};
                if (arg_left > 0)
                    arg_left = arg_left - 4'd1;
                if (arg_left == 0)
                begin
                    r.head_valid = 1'b1;
                    r.argument = arg_acc;
                    r.major_type = cur_major;
                    r.status = close_head(arg_acc, it.bytes_after);
                end
            end
            else
            begin
                if (skip_left > 0)
                    skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                begin
                    pphase = P_HEAD;
                    if (owed == 0)
                        r.status = cis_pkg::ST_DONE;
                end
            end
            if (r.status == cis_pkg::ST_RUN && it.bytes_after == 0)
                r.status = cis_pkg::ST_BAD;
            if (r.status != cis_pkg::ST_RUN)
            begin
                pphase = P_FINISHED;
                held = r.status;
            end
        end
        r.nesting_depth = levels;
        return r;
    endfunction

    function automatic void put_head(logic [2:0] mt, logic [63:0] v);
        int nb;
        if (v < 64'd24)
        begin
            gen_bytes.push_back({mt, v[4:0]});
            return;
        end
        if (v < 64'd256)
        begin
            gen_bytes.push_back({mt, AI_ARG1});
            nb = 1;
        end
        else if (v < 64'h10000)
        begin
            gen_bytes.push_back({mt, AI_ARG2});
            nb = 2;
        end
        else if (v < 64'h1_0000_0000)
        begin
            gen_bytes.push_back({mt, AI_ARG4});
            nb = 4;
        end
        else
        begin
            gen_bytes.push_back({mt, AI_ARG8});
            nb = 8;
        end
        for (int i = nb - 1; i >= 0; i--)
            gen_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic logic [63:0] random_arg();
        case ($urandom_range(0, 4))
            0: return 64'($urandom_range(0, 23));
            1: return 64'($urandom_range(24, 255));
            2: return 64'($urandom_range(256, 65535));
            3: return {32'd0, $urandom | 32'h10000};
            default: return {$urandom | 32'd1, $urandom};
        endcase
    endfunction

    function automatic void gen_value(int depth);
        logic [2:0] mt;
        int n;
        mt = 3'($urandom_range(0, 7));
        if (depth >= 3 && (mt == MT_ARRAY || mt == MT_MAP || mt == MT_TAG))
            mt = MT_UINT;
        case (mt)
            MT_UINT, MT_NINT: put_head(mt, random_arg());
            MT_BSTR, MT_TSTR:
            begin
                n = $urandom_range(0, 4);
                put_head(mt, 64'(n));
                repeat (n) gen_bytes.push_back(8'($urandom));
            end
            MT_ARRAY:
            begin
                n = $urandom_range(0, 3);
                put_head(mt, 64'(n));
                repeat (n) gen_value(depth + 1);
            end
            MT_MAP:
            begin
                n = $urandom_range(0, 2);
                put_head(mt, 64'(n));
                repeat (2 * n) gen_value(depth + 1);
            end
            MT_TAG:
            begin
                put_head(mt, random_arg());
                gen_value(depth + 1);
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: gen_bytes.push_back({MT_SIMPLE, 5'($urandom_range(0, 23))});
                    1:
                    begin
                        gen_bytes.push_back({MT_SIMPLE, AI_ARG1});
                        gen_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    default:
                    begin
                        n = $urandom_range(1, 3);
                        gen_bytes.push_back({MT_SIMPLE, 5'(AI_ARG1 + n)});
                        repeat (1 << n) gen_bytes.push_back(8'($urandom));
                    end
                endcase
            end
        endcase
    endfunction

    task automatic push_raw(logic [7:0] b, logic [31:0] after, logic rs);
        cis_pkg::item_t it;
        it.data_byte = b;
        it.bytes_after = after;
        it.restart = rs;
        pending_bytes.push_back(it);
    endtask

    task automatic queue_bytes(byte_q_t bq, logic [31:0] extra);
        for (int i = 0; i < bq.size(); i++)
            push_raw(bq[i], 32'(bq.size() - 1 - i) + extra, i == 0);
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (!(pending_bytes.size() == 0 && !push && expected_heads.size() == 0));
        repeat (24) @(posedge clk);
    endtask

    task automatic write_size(logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        msg_size = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(int budget);
        int sent;
        int cut;
        logic [31:0] extra;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    push_raw(8'($urandom), $urandom_range(0, 1) ? $urandom
                             : 32'($urandom_range(0, 4)), 1'($urandom));
                    sent++;
                end
            end
            else
            begin
                gen_bytes.delete();
                gen_value(0);
                case ($urandom_range(0, 9))
                    0: extra = $urandom_range(0, 32'hFFFF_FF00);
                    1, 2: extra = 32'($urandom_range(1, 3));
                    default: extra = 32'd0;
                endcase
                if ($urandom_range(0, 9) == 0)
                    gen_bytes[$urandom_range(0, gen_bytes.size() - 1)] = 8'($urandom);
                queue_bytes(gen_bytes, extra);
                if ($urandom_range(0, 9) == 0 && gen_bytes.size() > 1)
                begin
                    cut = $urandom_range(1, gen_bytes.size() - 1);
                    pending_bytes[pending_bytes.size() - cut].bytes_after = 0;
                end
                sent += gen_bytes.size();
                if ($urandom_range(0, 9) == 0)
                    push_raw(8'($urandom), 32'($urandom_range(0, 5)), 1'b0);
            end
        end
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;
    assign calm = (cycle_count >= 300 && cycle_count < 800);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                expected_heads.push_back(parse_byte(cur_item));
            if (push && full)
                ;
            else if (pending_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 20))
            begin
                cur_item = pending_bytes.pop_front();
                push <= 1'b1;
                data_byte <= cur_item.data_byte;
                bytes_after <= cur_item.bytes_after;
                restart <= cur_item.restart;
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cis_pkg::result_t want;
        cis_pkg::result_t got;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = '{status, head_valid, major_type, argument, nesting_depth};
                if (expected_heads.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    want = expected_heads.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            pop <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin
        #1_000_000;
        $display("tb_cbor_item_skipper failed");
        $finish;
    end

    initial
    begin
        msg_size = '0;
        clear_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_size(32'd16);
        queue_bytes('{8'h00}, 0);
        queue_bytes('{8'h17}, 0);
        queue_bytes('{8'h18, 8'h18}, 0);
        queue_bytes('{8'h18, 8'h05}, 0);
        queue_bytes('{8'h1b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 0);
        queue_bytes('{8'h3b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 0);
        queue_bytes('{8'h1c}, 3);
        queue_bytes('{8'h1f}, 3);
        queue_bytes('{8'hf8, 8'h10}, 0);
        queue_bytes('{8'hf8, 8'h20}, 0);
        queue_bytes('{8'hf9, 8'h00, 8'h00}, 0);
        queue_bytes('{8'hfb, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
        queue_bytes('{8'h40}, 0);
        queue_bytes('{8'h62, 8'h61, 8'h62}, 0);
        queue_bytes('{8'h45, 8'h01, 8'h02}, 0);
        queue_bytes('{8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81,
                      8'h00}, 0);
        queue_bytes('{8'ha1, 8'h00, 8'h00}, 0);
        queue_bytes('{8'hc1, 8'h00}, 0);
        queue_bytes('{8'h83, 8'h01, 8'h82, 8'h02, 8'h03, 8'h04}, 0);
        queue_bytes('{8'h84, 8'h00}, 0);
        queue_bytes('{8'h98, 8'h20}, 5);
        queue_bytes('{8'h9f}, 2);
        queue_bytes('{8'h00}, 2);
        push_raw(8'h01, 32'd1, 1'b0);
        push_raw(8'h02, 32'd0, 1'b0);
        queue_bytes('{8'h82, 8'h01}, 4);
        queue_bytes('{8'h00}, 0);
        random_items(100);
        wait_quiet();
        write_size(32'd0);
        random_items(80);
        wait_quiet();
        write_size(32'hFFFF_FFFF);
        queue_bytes('{8'hba, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00}, 0);
        queue_bytes('{8'h9a, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00}, 0);
        random_items(80);
        wait_quiet();
        write_size(32'($urandom_range(1, 3)));
        random_items(80);
        wait_quiet();
        if (errors == 0 && expected_heads.size() == 0)
            $display("tb_cbor_item_skipper passed");
        else
            $display("tb_cbor_item_skipper failed");
        $finish;
    end
endmodule
